/* rtl/e2g_pkg.sv */
// Shared types, constants and the arctangent table of the ECEF to geodetic converter.
`default_nettype none
package e2g_pkg;

  // Number of latitude refinement passes.
  localparam int ITERATIONS = 12;
  localparam int ITER_W = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

  // CORDIC micro-rotations per call.
  localparam int CORDIC_STEPS = 40;
  localparam int STEP_W = $clog2(CORDIC_STEPS);

  // Bit-serial divider: numerator width and width of the bit counter.
  localparam int DIV_NUM_W = 110;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // Square root: steps over a 64 bit radicand, two radicand bits and one result bit each.
  localparam int SQRT_STEPS = 32;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

  localparam logic signed [63:0] PI_Q60      = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] HALF_PI_Q60 = PI_Q60 >>> 1;
  localparam logic signed [63:0] INVGAIN_Q40 = 64'sh0000009B74EDA843;
  localparam logic [63:0]        QUOT_LIMIT  = 64'h4000000000000000;
  localparam logic signed [63:0] LAT_MAX     = 64'sd843314857;
  localparam logic signed [63:0] LON_MAX     = 64'sd1686629713;
  localparam logic signed [63:0] H_MAX       = 64'sd549755813887;
  localparam logic signed [63:0] H_MIN       = -64'sd549755813888;
  localparam logic signed [63:0] ONE_Q40     = 64'sh0000010000000000;

  // Register reset values.
  localparam logic [38:0] SMA_RESET  = 39'd6378137000;
  localparam logic [28:0] FLAT_RESET = 29'd14400212;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SMA  = 2'd0;
  localparam logic [1:0] CFG_FLAT = 2'd1;

  // One input beat.
  typedef struct packed {
    logic signed [39:0] ecef_x;
    logic signed [39:0] ecef_y;
    logic signed [39:0] ecef_z;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic signed [30:0] latitude;
    logic signed [31:0] longitude;
    logic signed [39:0] height;
  } out_item_t;

  // CORDIC request: rotation mode when rot is set, vectoring otherwise.
  typedef struct packed {
    logic               rot;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } cordic_req_t;

  // CORDIC result: gain-scaled magnitude or cosine in x, sine in y, angle in z.
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } cordic_res_t;

  typedef logic [CORDIC_STEPS-1:0][63:0] atan_tab_t;

  // atan(2^-i) in Q60 as a truncated alternating series, evaluated at elaboration.
  function automatic atan_tab_t build_atan();
    atan_tab_t          tab;
    logic signed [63:0] sum;
    logic [63:0]        term;
    int                 sh;
    tab[0] = PI_Q60 >>> 2;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      sum = '0;
      for (int n = 0; n < 31; n++) begin
        sh = i * (2 * n + 1);
        if (sh <= 60) begin
          term = (64'd1 << (60 - sh)) / 64'(2 * n + 1);
          if (n[0]) begin
            sum = sum - $signed(term);
          end else begin
            sum = sum + $signed(term);
          end
        end
      end
      tab[i] = sum;
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

endpackage
`default_nettype wire

/* rtl/e2g_mul.sv */
// Sequential 64 x 64 signed multiplier with rounded, saturated right shift.
`default_nettype none
module e2g_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  input  wire logic               sh32,
  output logic                    done,
  output logic signed [63:0]      res
);
  import e2g_pkg::*;

  logic [63:0]        ua_r, ub_r;
  logic               neg_r, sh32_r, busy_r, done_r;
  logic [2:0]         step_r;
  logic [1:0]         psel_r;
  logic [63:0]        pp_r;
  logic [127:0]       acc_r;
  logic signed [63:0] res_r;

  logic [31:0]  op_a, op_b;
  logic [127:0] pp_shifted;
  logic [127:0] q_wide;
  logic [63:0]  q_sat;

  // Operand halves for the partial product of this step.
  always_comb begin
    op_a = (step_r == 3'd2 || step_r == 3'd3) ? ua_r[63:32] : ua_r[31:0];
    op_b = (step_r == 3'd1 || step_r == 3'd3) ? ub_r[63:32] : ub_r[31:0];
  end

  // Alignment of the previous partial product.
  always_comb begin
    unique case (psel_r)
      2'd0:    pp_shifted = {64'd0, pp_r};
      2'd1:    pp_shifted = {32'd0, pp_r, 32'd0};
      default: pp_shifted = {pp_r, 64'd0};
    endcase
  end

  // Scaled magnitude, clamped to the largest positive value.
  always_comb begin
    q_wide = sh32_r ? (acc_r >> 32) : (acc_r >> 40);
    q_sat  = (|q_wide[127:63]) ? 64'h7FFFFFFFFFFFFFFF : q_wide[63:0];
  end

  // Step sequence: four partial products, accumulate, round, finish.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ua_r   <= a[63] ? 64'(-a) : 64'(a);
        ub_r   <= b[63] ? 64'(-b) : 64'(b);
        neg_r  <= a[63] ^ b[63];
        sh32_r <= sh32;
        acc_r  <= '0;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r <= 3'd3) begin
          pp_r   <= op_a * op_b;
          psel_r <= (step_r == 3'd0) ? 2'd0 : ((step_r == 3'd3) ? 2'd2 : 2'd1);
        end
        if (step_r >= 3'd1 && step_r <= 3'd4) begin
          acc_r <= acc_r + pp_shifted;
        end
        if (step_r == 3'd5) begin
          acc_r <= acc_r + (sh32_r ? (128'd1 << 31) : (128'd1 << 39));
        end
        if (step_r == 3'd6) begin
          res_r  <= neg_r ? -$signed(q_sat) : $signed(q_sat);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

/* rtl/e2g_sqrt.sv */
// Bitwise floor square root, two radicand bits per cycle.
`default_nettype none
module e2g_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] v,
  output logic             done,
  output logic [31:0]      root
);
  import e2g_pkg::*;

  logic [63:0]           v_r, res_r, bit_r;
  logic [SQRT_CNT_W-1:0] cnt_r;
  logic                  busy_r, done_r;
  logic [63:0]           trial;

  assign trial = res_r + bit_r;

  // One result bit per cycle, starting from the top even bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= v;
        res_r  <= '0;
        bit_r  <= 64'd1 << 62;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule
`default_nettype wire

/* rtl/e2g_div.sv */
// Restoring bit-serial divider with quotient saturation at 2^62.
`default_nettype none
module e2g_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [e2g_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [63:0]                   den,
  output logic                               done,
  output logic [63:0]                        quot
);
  import e2g_pkg::*;

  logic [DIV_NUM_W-1:0] num_r;
  logic [63:0]          den_r, rem_r, q_r;
  logic                 sat_r, busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  logic [64:0] trial;
  logic        ge;
  logic [63:0] q_next;

  // Shift in the next numerator bit and try a subtraction.
  always_comb begin
    trial  = {rem_r, num_r[DIV_NUM_W-1]};
    ge     = trial >= {1'b0, den_r};
    q_next = {q_r[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
        sat_r  <= (den == 64'd0);
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        num_r <= num_r << 1;
        rem_r <= ge ? 64'(trial - {1'b0, den_r}) : trial[63:0];
        q_r   <= q_next;
        // Once the quotient passes the limit it only grows, so the flag sticks.
        if (q_next > QUOT_LIMIT) begin
          sat_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = sat_r ? QUOT_LIMIT : q_r;

endmodule
`default_nettype wire

/* rtl/e2g_cordic.sv */
// Iterative CORDIC engine for vectoring (atan2 and magnitude) and rotation (cos, sin).
`default_nettype none
module e2g_cordic (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire e2g_pkg::cordic_req_t req,
  output logic                      done,
  output e2g_pkg::cordic_res_t      res
);
  import e2g_pkg::*;

  logic signed [63:0] x_r, y_r, z_r;
  logic               rot_r, busy_r, done_r;
  logic [STEP_W-1:0]  step_r;

  logic signed [63:0] xs, ys, atan_i;
  logic               dneg;

  // Shifted terms and direction of this micro-rotation.
  always_comb begin
    xs     = x_r >>> step_r;
    ys     = y_r >>> step_r;
    atan_i = $signed(ATAN_TAB[step_r]);
    dneg   = rot_r ? ~z_r[63] : y_r[63];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rot_r  <= req.rot;
        step_r <= '0;
        busy_r <= 1'b1;
        if (req.rot) begin
          x_r <= INVGAIN_Q40;
          y_r <= '0;
          z_r <= req.z;
        end else if (req.x == 64'sd0 && req.y == 64'sd0) begin
          // Zero vector: angle and magnitude are zero.
          x_r    <= '0;
          y_r    <= '0;
          z_r    <= '0;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else if (req.x[63]) begin
          // Left half plane: pre-rotate by a quarter turn.
          if (!req.y[63]) begin
            x_r <= req.y;
            y_r <= -req.x;
            z_r <= HALF_PI_Q60;
          end else begin
            x_r <= -req.y;
            y_r <= req.x;
            z_r <= -HALF_PI_Q60;
          end
        end else begin
          x_r <= req.x;
          y_r <= req.y;
          z_r <= '0;
        end
      end else if (busy_r) begin
        if (dneg) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_i;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_i;
        end
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign res.x = x_r;
  assign res.y = y_r;
  assign res.z = z_r;

endmodule
`default_nettype wire

/* rtl/ecef_to_geodetic.sv */
// Top level: ECEF to geodetic converter with its sequencer and output register.
//
//   Channel   Direction  Handshake            Payload
//   in_*      input      in_valid / in_stall  ecef_x, ecef_y, ecef_z
//   out_*     output     out_valid/out_stall  latitude, longitude, height
//   cfg_*     input      cfg_we               cfg_index, cfg_wdata
//
// The height division is skipped when p <= 0 (polar axis) or cos B <= 0. Each pass runs,
// one after another: a CORDIC rotation, two multiplies, the square root, the division,
// two more multiplies and a CORDIC vectoring.
// in_stall is high from acceptance until the result is loaded into the output
// register; a held result stalls only the final load. Reset is synchronous.
`default_nettype none
module ecef_to_geodetic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire e2g_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output e2g_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [38:0]        cfg_wdata
);
  import e2g_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LON  = 4'd1;
  localparam logic [3:0] S_P    = 4'd2;
  localparam logic [3:0] S_LAT0 = 4'd3;
  localparam logic [3:0] S_ROT  = 4'd4;
  localparam logic [3:0] S_S2   = 4'd5;
  localparam logic [3:0] S_ES2  = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_NDIV = 4'd8;
  localparam logic [3:0] S_T1   = 4'd9;
  localparam logic [3:0] S_T2   = 4'd10;
  localparam logic [3:0] S_VEC  = 4'd11;
  localparam logic [3:0] S_HDIV = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [38:0]        sma_r;
  logic [28:0]        flat_r;
  logic [3:0]         state_r;
  logic signed [63:0] z16_r, lon_r, lat_r, p16_r, c_r, s_r, n16_r;
  logic [63:0]        q_r;
  logic [29:0]        e2_r;
  logic [ITER_W-1:0]  iter_r;
  logic               final_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // Unit requests.
  logic               cord_start_r, mul_start_r, sqrt_start_r, div_start_r;
  cordic_req_t        cord_req_r;
  logic signed [63:0] mul_a_r, mul_b_r;
  logic               mul_sh32_r;
  logic [63:0]        sqrt_v_r;
  logic [DIV_NUM_W-1:0] div_num_r;
  logic [63:0]        div_den_r;

  // Unit results.
  logic               cord_done, mul_done, sqrt_done, div_done;
  cordic_res_t        cord_res;
  logic signed [63:0] mul_res;
  logic [31:0]        sqrt_root;
  logic [63:0]        div_quot;

  logic               in_acc;
  logic signed [63:0] x16, y16, z16;
  logic [57:0]        f_sq;
  logic [29:0]        e2_new;
  logic signed [63:0] w_full;
  logic [40:0]        w_cl;
  logic signed [63:0] e2_wide;
  logic signed [63:0] lat_rs, lon_rs, h16, h_rs;
  out_item_t          fmt;
  logic               out_load;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Coordinates in Q16 mm and squared eccentricity in Q32.
  always_comb begin
    x16    = {{8{in_data.ecef_x[39]}}, in_data.ecef_x, 16'h0000};
    y16    = {{8{in_data.ecef_y[39]}}, in_data.ecef_y, 16'h0000};
    z16    = {{8{in_data.ecef_z[39]}}, in_data.ecef_z, 16'h0000};
    f_sq   = flat_r * flat_r;
    e2_new = {flat_r, 1'b0} - 30'((59'(f_sq) + 59'(64'd1 << 31)) >> 32);
    e2_wide = $signed({34'd0, e2_r});
  end

  // Square root argument 1 - e2 sin^2 in Q40, kept within [1, 2^40].
  always_comb begin
    w_full = ONE_Q40 - mul_res;
    if (w_full < 64'sd1) begin
      w_cl = 41'd1;
    end else if (w_full > ONE_Q40) begin
      w_cl = 41'h10000000000;
    end else begin
      w_cl = w_full[40:0];
    end
  end

  // Output rounding and clamping.
  always_comb begin
    lat_rs = (lat_r + 64'sd1073741824) >>> 31;
    lon_rs = (lon_r + 64'sd1073741824) >>> 31;
    h16    = $signed(q_r) - n16_r;
    h_rs   = (h16 + 64'sd32768) >>> 16;
    if (lat_rs > LAT_MAX) begin
      fmt.latitude = 31'(LAT_MAX);
    end else if (lat_rs < -LAT_MAX) begin
      fmt.latitude = 31'(-LAT_MAX);
    end else begin
      fmt.latitude = lat_rs[30:0];
    end
    if (lon_rs > LON_MAX) begin
      fmt.longitude = 32'(LON_MAX);
    end else if (lon_rs < -LON_MAX) begin
      fmt.longitude = 32'(-LON_MAX);
    end else begin
      fmt.longitude = lon_rs[31:0];
    end
    if (h_rs > H_MAX) begin
      fmt.height = 40'(H_MAX);
    end else if (h_rs < H_MIN) begin
      fmt.height = 40'(H_MIN);
    end else begin
      fmt.height = h_rs[39:0];
    end
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sma_r  <= SMA_RESET;
      flat_r <= FLAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SMA:  sma_r  <= cfg_wdata;
        CFG_FLAT: flat_r <= cfg_wdata[28:0];
        default:  ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      out_data_r  <= fmt;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Sequencer over the shared CORDIC, multiplier, square root and divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cord_start_r <= 1'b0;
      mul_start_r  <= 1'b0;
      sqrt_start_r <= 1'b0;
      div_start_r  <= 1'b0;
      iter_r       <= '0;
      final_r      <= 1'b0;
    end else begin
      cord_start_r <= 1'b0;
      mul_start_r  <= 1'b0;
      sqrt_start_r <= 1'b0;
      div_start_r  <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            z16_r        <= z16;
            e2_r         <= e2_new;
            cord_req_r   <= '{rot: 1'b0, x: x16, y: y16, z: 64'sd0};
            cord_start_r <= 1'b1;
            state_r      <= S_LON;
          end
        end
        S_LON: begin
          if (cord_done) begin
            lon_r       <= cord_res.z;
            mul_a_r     <= cord_res.x;
            mul_b_r     <= INVGAIN_Q40;
            mul_sh32_r  <= 1'b0;
            mul_start_r <= 1'b1;
            state_r     <= S_P;
          end
        end
        S_P: begin
          if (mul_done) begin
            p16_r        <= mul_res;
            cord_req_r   <= '{rot: 1'b0, x: mul_res, y: z16_r, z: 64'sd0};
            cord_start_r <= 1'b1;
            state_r      <= S_LAT0;
          end
        end
        S_LAT0: begin
          if (cord_done) begin
            lat_r        <= cord_res.z;
            iter_r       <= '0;
            final_r      <= 1'b0;
            cord_req_r   <= '{rot: 1'b1, x: 64'sd0, y: 64'sd0, z: cord_res.z};
            cord_start_r <= 1'b1;
            state_r      <= S_ROT;
          end
        end
        S_ROT: begin
          if (cord_done) begin
            c_r         <= cord_res.x;
            s_r         <= cord_res.y;
            mul_a_r     <= cord_res.y;
            mul_b_r     <= cord_res.y;
            mul_sh32_r  <= 1'b0;
            mul_start_r <= 1'b1;
            state_r     <= S_S2;
          end
        end
        S_S2: begin
          if (mul_done) begin
            mul_a_r     <= e2_wide;
            mul_b_r     <= mul_res;
            mul_sh32_r  <= 1'b1;
            mul_start_r <= 1'b1;
            state_r     <= S_ES2;
          end
        end
        S_ES2: begin
          if (mul_done) begin
            sqrt_v_r     <= {3'd0, w_cl, 20'd0};
            sqrt_start_r <= 1'b1;
            state_r      <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            div_num_r   <= {25'd0, sma_r, 46'd0};
            div_den_r   <= {32'd0, sqrt_root};
            div_start_r <= 1'b1;
            state_r     <= S_NDIV;
          end
        end
        S_NDIV: begin
          if (div_done) begin
            n16_r <= $signed(div_quot);
            if (final_r) begin
              // Height term p / cos B, with the polar and overflow cases.
              if (p16_r <= 64'sd0) begin
                q_r     <= '0;
                state_r <= S_OUT;
              end else if (c_r <= 64'sd0) begin
                q_r     <= QUOT_LIMIT;
                state_r <= S_OUT;
              end else begin
                div_num_r   <= {6'd0, p16_r, 40'd0};
                div_den_r   <= c_r;
                div_start_r <= 1'b1;
                state_r     <= S_HDIV;
              end
            end else begin
              mul_a_r     <= $signed(div_quot);
              mul_b_r     <= e2_wide;
              mul_sh32_r  <= 1'b1;
              mul_start_r <= 1'b1;
              state_r     <= S_T1;
            end
          end
        end
        S_T1: begin
          if (mul_done) begin
            mul_a_r     <= mul_res;
            mul_b_r     <= s_r;
            mul_sh32_r  <= 1'b0;
            mul_start_r <= 1'b1;
            state_r     <= S_T2;
          end
        end
        S_T2: begin
          if (mul_done) begin
            cord_req_r   <= '{rot: 1'b0, x: p16_r, y: z16_r + mul_res, z: 64'sd0};
            cord_start_r <= 1'b1;
            state_r      <= S_VEC;
          end
        end
        S_VEC: begin
          if (cord_done) begin
            lat_r  <= cord_res.z;
            iter_r <= iter_r + 1'b1;
            if (iter_r == ITER_W'(ITERATIONS - 1)) begin
              final_r <= 1'b1;
            end
            cord_req_r   <= '{rot: 1'b1, x: 64'sd0, y: 64'sd0, z: cord_res.z};
            cord_start_r <= 1'b1;
            state_r      <= S_ROT;
          end
        end
        S_HDIV: begin
          if (div_done) begin
            q_r     <= div_quot;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  e2g_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start_r),
    .req   (cord_req_r),
    .done  (cord_done),
    .res   (cord_res)
  );

  e2g_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .sh32  (mul_sh32_r),
    .done  (mul_done),
    .res   (mul_res)
  );

  e2g_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start_r),
    .v     (sqrt_v_r),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  e2g_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
